[src/rmm_pkg.sv]
// Shared types, constants and tables of the stereo ring modulator.
`default_nettype none
package rmm_pkg;

	localparam int FRAC_BITS = 19;
	localparam int DIV_QBITS = 24;
	localparam int DIV_NBITS = 52;
	localparam int DIV_DBITS = 32;

	localparam logic signed [32:0] Q_ONE      = 33'sd524288;
	localparam logic signed [32:0] K_DIODE    = 33'sd185747278;
	localparam logic signed [32:0] K_LIGHT    = 33'sd159072863;
	localparam logic signed [32:0] K_SUM      = 33'sd751619277;
	localparam logic signed [32:0] K_MIX      = 33'sd811647363;
	localparam logic signed [32:0] K_CMP      = 33'sd283400204;
	localparam logic signed [32:0] DIODE_KNEE = 33'sd349700;
	localparam logic signed [32:0] SOFT_K     = 33'sd14155776;
	localparam logic signed [32:0] LIGHT_CLIP = 33'sd786432;

	localparam logic [7:0] CFG_PHASE_STEP   = 8'd0;
	localparam logic [7:0] CFG_CARRIER_WAVE = 8'd1;
	localparam logic [7:0] CFG_RING_MODEL   = 8'd2;
	localparam logic [7:0] CFG_DRIVE_GAIN   = 8'd3;

	localparam logic [1:0] WAVE_SINE   = 2'd0;
	localparam logic [1:0] WAVE_TRI    = 2'd1;
	localparam logic [1:0] WAVE_SAW    = 2'd2;
	localparam logic [1:0] WAVE_SQUARE = 2'd3;

	localparam logic [2:0] MODEL_MUL     = 3'd0;
	localparam logic [2:0] MODEL_DIGITAL = 3'd1;
	localparam logic [2:0] MODEL_DIODE   = 3'd2;
	localparam logic [2:0] MODEL_XOR     = 3'd3;
	localparam logic [2:0] MODEL_CMP     = 3'd4;

	typedef enum logic [5:0] {
		OP_NOP, OP_CAPTURE, OP_CARRIER, OP_LOADX, OP_STORE, OP_PUSH,
		OP_M_XC, OP_M_R0G, OP_M_R1R1, OP_M_R1KD, OP_M_R2R2, OP_M_R2KD,
		OP_M_R0R0, OP_M_R0R2, OP_M_R1R0, OP_M_R1KL, OP_M_R2KS, OP_M_R2KX,
		OP_M_R2KC,
		OP_A_RES_P19, OP_A_R0_P19, OP_A_SATABS, OP_A_RES_Q, OP_A_DIODE,
		OP_A_R1_P19, OP_A_R1_MAG, OP_A_R2_P19, OP_A_RING, OP_A_SOFT_PREP,
		OP_A_LIGHT, OP_A_XOR, OP_A_SUMDIFF, OP_A_RES_R0P30, OP_A_CMP,
		OP_DIV1, OP_DIV2
	} op_e;

	typedef enum logic [2:0] {
		ST_IDLE, ST_CARRIER, ST_LOADX, ST_RUN, ST_DIV_WAIT, ST_STORE, ST_PUSH
	} state_e;

	typedef struct packed {
		op_e  op;
		logic chan;
	} cmd_t;

	typedef struct packed {
		logic [2:0] model;
		logic       div_busy;
	} stat_t;

	typedef logic signed [20:0] sine_lut_t [0:256];

	// One quarter wave of the sine in Q19, worked out at elaboration.
	function automatic sine_lut_t build_sine_lut();
		sine_lut_t lut;
		longint t;
		longint s;
		longint p;
		longint v;
		for (int i = 0; i <= 256; i++) begin
			t = longint'(i) <<< 22;
			s = (t * t) >>> 30;
			p = 3864;
			p = 172272 - ((p * s) >>> 30);
			p = 5026995 - ((p * s) >>> 30);
			p = 85569306 - ((p * s) >>> 30);
			p = 693598668 - ((p * s) >>> 30);
			p = 1686629713 - ((p * s) >>> 30);
			v = (p * t) >>> 30;
			v = (v + 1024) >>> 11;
			if (v > 524288) begin
				v = 524288;
			end
			lut[i] = 21'(v);
		end
		return lut;
	endfunction

	localparam sine_lut_t SINE_LUT = build_sine_lut();

endpackage
`default_nettype wire

[src/rmm_div.sv]
// Restoring divider that yields one quotient bit per cycle.
`default_nettype none
module rmm_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [rmm_pkg::DIV_NBITS-1:0]  num,
	input  wire logic [rmm_pkg::DIV_DBITS-1:0]  den,
	output logic                                busy,
	output logic [rmm_pkg::DIV_QBITS-1:0]       quo
);
	import rmm_pkg::*;

	localparam int CW = $clog2(DIV_QBITS + 1);

	logic [CW-1:0]        cnt_q;
	logic [DIV_DBITS:0]   rem_q;
	logic [DIV_DBITS-1:0] den_q;
	logic [DIV_QBITS-1:0] low_q;
	logic [DIV_QBITS-1:0] quo_q;
	logic [DIV_DBITS:0]   trial;
	logic                 fits;

	assign trial = {rem_q[DIV_DBITS-1:0], low_q[DIV_QBITS-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign busy  = cnt_q != '0;
	assign quo   = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(DIV_QBITS);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= (DIV_DBITS + 1)'(num[DIV_NBITS-1:DIV_QBITS]);
			low_q <= num[DIV_QBITS-1:0];
			den_q <= den;
		end else if (busy) begin
			rem_q <= fits ? trial - {1'b0, den_q} : trial;
			low_q <= {low_q[DIV_QBITS-2:0], 1'b0};
			quo_q <= {quo_q[DIV_QBITS-2:0], fits};
		end
	end
endmodule
`default_nettype wire

[src/rmm_datapath.sv]
// Datapath: configuration, phase accumulator, carrier, shared multiplier and result registers.
`default_nettype none
module rmm_datapath (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire rmm_pkg::cmd_t  cmd,
	output rmm_pkg::stat_t      stat,
	input  wire logic [31:0]    s_tdata,
	output logic [31:0]         m_tdata,
	input  wire logic           cfg_valid,
	input  wire logic [7:0]     cfg_index,
	input  wire logic [31:0]    cfg_data
);
	import rmm_pkg::*;

	logic [31:0] phase_q, step_q;
	logic [1:0]  wave_q;
	logic [2:0]  model_q;
	logic [14:0] gain_q;

	logic [15:0]        samp_l_q, samp_r_q;
	logic signed [19:0] x_q;
	logic signed [20:0] c_q;
	logic signed [65:0] p_q;
	logic signed [32:0] r0_q, r1_q, r2_q, r3_q, res_q;
	logic               neg_q, s1_q, s2_q;
	logic [15:0]        res_l_q, res_r_q;
	logic [31:0]        out_q;

	logic signed [32:0] xw, cw, ma, mb;
	logic signed [65:0] prod, p10, p19, p30;
	logic               mul_en;
	logic signed [32:0] mag30, res_sh4;
	logic [15:0]        res_code;

	logic [9:0]         idx;
	logic [8:0]         ti;
	logic signed [20:0] sv, carrier;
	logic [31:0]        dmag;

	logic signed [20:0] cdiv;
	logic [15:0]        ib, xbits;

	logic signed [32:0] v1, v2, a1, a2, d1, d2;
	logic signed [23:0] y24;
	logic signed [32:0] yabs, a2sq, aa, ab, light_r;

	logic                 div_start, div_busy;
	logic [DIV_NBITS-1:0] div_num;
	logic [DIV_DBITS-1:0] div_den;
	logic [DIV_QBITS-1:0] div_quo;
	logic signed [32:0]   quo_s;

	function automatic logic signed [32:0] abs33(input logic signed [32:0] v);
		return v < 0 ? -v : v;
	endfunction

	assign xw = {{13{x_q[19]}}, x_q};
	assign cw = {{12{c_q[20]}}, c_q};

	// Carrier from the phase as it stands before the increment.
	assign idx = phase_q[31:22];
	assign ti  = idx[8] ? 9'd256 - {1'b0, idx[7:0]} : {1'b0, idx[7:0]};
	assign sv  = SINE_LUT[ti];
	assign dmag = phase_q[31] ? phase_q - 32'h8000_0000 : 32'h8000_0000 - phase_q;

	always_comb begin
		case (wave_q)
			WAVE_SINE:   carrier = idx[9] ? -sv : sv;
			WAVE_SAW:    carrier = $signed({1'b0, phase_q[31:12]}) - 21'sd524288;
			WAVE_SQUARE: carrier = phase_q[31] ? -21'sd524288 : 21'sd524288;
			default:     carrier = 21'(22'sd524288 - $signed({1'b0, dmag[31:11]}));
		endcase
	end

	always_comb begin
		mul_en = 1'b1;
		ma = r0_q;
		mb = r0_q;
		case (cmd.op)
			OP_M_XC:   begin ma = xw;   mb = cw;      end
			OP_M_R0G:  begin ma = r0_q; mb = $signed({18'd0, gain_q}); end
			OP_M_R1R1: begin ma = r1_q; mb = r1_q;    end
			OP_M_R1KD: begin ma = r1_q; mb = K_DIODE; end
			OP_M_R2R2: begin ma = r2_q; mb = r2_q;    end
			OP_M_R2KD: begin ma = r2_q; mb = K_DIODE; end
			OP_M_R0R0: begin ma = r0_q; mb = r0_q;    end
			OP_M_R0R2: begin ma = r0_q; mb = r2_q;    end
			OP_M_R1R0: begin ma = r1_q; mb = r0_q;    end
			OP_M_R1KL: begin ma = r1_q; mb = K_LIGHT; end
			OP_M_R2KS: begin ma = r2_q; mb = K_SUM;   end
			OP_M_R2KX: begin ma = r2_q; mb = K_MIX;   end
			OP_M_R2KC: begin ma = r2_q; mb = K_CMP;   end
			default:   mul_en = 1'b0;
		endcase
	end

	assign prod  = ma * mb;
	assign p10   = p_q >>> 10;
	assign p19   = p_q >>> FRAC_BITS;
	assign p30   = p_q >>> 30;
	assign mag30 = p30[32:0];

	assign y24  = (p10 > 66'sd8388607) ? 24'sd8388607 :
		(p10 < -66'sd8388608) ? -24'sd8388608 : p10[23:0];
	assign yabs = abs33({{9{y24[23]}}, y24});

	assign v1 = xw + cw;
	assign v2 = xw - cw;
	assign a1 = abs33(v1) - DIODE_KNEE;
	assign a2 = abs33(v2) - DIODE_KNEE;
	assign d1 = a1 < 0 ? '0 : a1;
	assign d2 = a2 < 0 ? '0 : a2;

	assign a2sq = p19[32:0];

	assign aa = abs33(xw);
	assign ab = abs33(cw);

	assign light_r = (r0_q >= LIGHT_CLIP) ? Q_ONE : r0_q - mag30;

	// Carrier code for the XOR model: truncation toward zero, then saturation.
	assign cdiv  = c_q[20] ? -((-c_q) >>> 4) : c_q >>> 4;
	assign ib    = (cdiv > 21'sd32767) ? 16'h7fff :
		(cdiv < -21'sd32768) ? 16'h8000 : cdiv[15:0];
	assign xbits = x_q[19:4] ^ ib;

	assign res_sh4  = res_q >>> 4;
	assign res_code = (res_sh4 > 33'sd32767) ? 16'h7fff :
		(res_sh4 < -33'sd32768) ? 16'h8000 : res_sh4[15:0];

	assign div_start = (cmd.op == OP_DIV1) || (cmd.op == OP_DIV2);
	assign div_num   = (cmd.op == OP_DIV1) ? {9'd0, r0_q[23:0], 19'd0} : p_q[DIV_NBITS-1:0];
	assign div_den   = (cmd.op == OP_DIV1) ? 32'(Q_ONE + r0_q) : r3_q[DIV_DBITS-1:0];
	assign quo_s     = $signed({9'd0, div_quo});

	rmm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	assign stat.model    = model_q;
	assign stat.div_busy = div_busy;
	assign m_tdata       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			step_q  <= '0;
			wave_q  <= '0;
			model_q <= '0;
			gain_q  <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_PHASE_STEP:   step_q  <= cfg_data;
					CFG_CARRIER_WAVE: wave_q  <= cfg_data[1:0];
					CFG_RING_MODEL:   model_q <= cfg_data[2:0];
					CFG_DRIVE_GAIN:   gain_q  <= cfg_data[14:0];
					default: ;
				endcase
			end
			if (cmd.op == OP_CARRIER) begin
				phase_q <= phase_q + step_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mul_en) begin
			p_q <= prod;
		end
		case (cmd.op)
			OP_CAPTURE: begin
				samp_l_q <= s_tdata[15:0];
				samp_r_q <= s_tdata[31:16];
			end
			OP_CARRIER:   c_q <= carrier;
			OP_LOADX:     x_q <= {cmd.chan ? samp_r_q : samp_l_q, 4'b0000};
			OP_A_RES_P19: res_q <= p19[32:0];
			OP_A_R0_P19:  r0_q <= p19[32:0];
			OP_A_SATABS: begin
				r0_q  <= yabs;
				neg_q <= y24[23];
			end
			OP_A_RES_Q:   res_q <= neg_q ? -quo_s : quo_s;
			OP_A_DIODE: begin
				r1_q <= d1;
				r2_q <= d2;
				s1_q <= v1 > 0;
				s2_q <= v2 > 0;
			end
			OP_A_R1_P19:  r1_q <= p19[32:0];
			OP_A_R1_MAG:  r1_q <= s1_q ? mag30 : -mag30;
			OP_A_R2_P19:  r2_q <= p19[32:0];
			OP_A_RING:    r0_q <= r1_q + (s2_q ? mag30 : -mag30);
			OP_A_SOFT_PREP: begin
				r2_q <= SOFT_K + a2sq;
				r3_q <= SOFT_K + (a2sq <<< 3) + a2sq;
			end
			OP_A_LIGHT:   res_q <= neg_q ? -light_r : light_r;
			OP_A_XOR: begin
				r1_q <= {{13{xbits[15]}}, xbits, 4'b0000};
				r2_q <= v1;
			end
			OP_A_SUMDIFF: begin
				r0_q <= mag30;
				r2_q <= r1_q - mag30;
			end
			OP_A_RES_R0P30: res_q <= r0_q + mag30;
			OP_A_CMP: begin
				if (aa > ab) begin
					r0_q <= xw;
					r2_q <= aa - xw;
				end else begin
					r0_q <= cw;
					r2_q <= -ab - cw;
				end
			end
			OP_STORE: begin
				if (cmd.chan) begin
					res_r_q <= res_code;
				end else begin
					res_l_q <= res_code;
				end
			end
			OP_PUSH:      out_q <= {res_r_q, res_l_q};
			default: ;
		endcase
	end
endmodule
`default_nettype wire

[src/rmm_ctrl.sv]
// Controller: sequences the datapath through each model's steps, one channel after the other.
`default_nettype none
module rmm_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  wire logic           m_tready,
	input  wire rmm_pkg::stat_t stat,
	output rmm_pkg::cmd_t       cmd
);
	import rmm_pkg::*;

	typedef struct packed {
		op_e  op;
		logic last;
	} ustep_t;

	state_e     state_q, state_d;
	logic [4:0] pc_q, pc_d;
	logic       chan_q, chan_d;
	logic       out_valid_q;
	ustep_t     st;

	function automatic ustep_t prog(input logic [2:0] model, input logic [4:0] pc);
		ustep_t s;
		s.op   = OP_NOP;
		s.last = 1'b0;
		case (model)
			MODEL_MUL: begin
				case (pc)
					5'd0:    s.op = OP_M_XC;
					default: begin s.op = OP_A_RES_P19; s.last = 1'b1; end
				endcase
			end
			MODEL_DIGITAL: begin
				case (pc)
					5'd0:    s.op = OP_M_XC;
					5'd1:    s.op = OP_A_R0_P19;
					5'd2:    s.op = OP_M_R0G;
					5'd3:    s.op = OP_A_SATABS;
					5'd4:    s.op = OP_DIV1;
					default: begin s.op = OP_A_RES_Q; s.last = 1'b1; end
				endcase
			end
			MODEL_XOR: begin
				case (pc)
					5'd0:    s.op = OP_A_XOR;
					5'd1:    s.op = OP_M_R2KS;
					5'd2:    s.op = OP_A_SUMDIFF;
					5'd3:    s.op = OP_M_R2KX;
					default: begin s.op = OP_A_RES_R0P30; s.last = 1'b1; end
				endcase
			end
			MODEL_CMP: begin
				case (pc)
					5'd0:    s.op = OP_A_CMP;
					5'd1:    s.op = OP_M_R2KC;
					default: begin s.op = OP_A_RES_R0P30; s.last = 1'b1; end
				endcase
			end
			default: begin
				case (pc)
					5'd0:  s.op = OP_A_DIODE;
					5'd1:  s.op = OP_M_R1R1;
					5'd2:  s.op = OP_A_R1_P19;
					5'd3:  s.op = OP_M_R1KD;
					5'd4:  s.op = OP_A_R1_MAG;
					5'd5:  s.op = OP_M_R2R2;
					5'd6:  s.op = OP_A_R2_P19;
					5'd7:  s.op = OP_M_R2KD;
					5'd8:  s.op = OP_A_RING;
					5'd9:  s.op = OP_M_R0G;
					5'd10: s.op = OP_A_SATABS;
					5'd11: s.op = OP_M_R0R0;
					5'd12: s.op = (model == MODEL_DIODE) ? OP_A_SOFT_PREP : OP_A_R1_P19;
					5'd13: s.op = (model == MODEL_DIODE) ? OP_M_R0R2 : OP_M_R1R0;
					5'd14: s.op = (model == MODEL_DIODE) ? OP_DIV2 : OP_A_R1_P19;
					5'd15: begin
						if (model == MODEL_DIODE) begin
							s.op   = OP_A_RES_Q;
							s.last = 1'b1;
						end else begin
							s.op = OP_M_R1KL;
						end
					end
					default: begin s.op = OP_A_LIGHT; s.last = 1'b1; end
				endcase
			end
		endcase
		return s;
	endfunction

	assign st       = prog(stat.model, pc_q);
	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pc_q        <= '0;
			chan_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
			chan_q  <= chan_d;
			if (cmd.op == OP_PUSH) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		pc_d     = pc_q;
		chan_d   = chan_q;
		cmd.op   = OP_NOP;
		cmd.chan = chan_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.op  = OP_CAPTURE;
					state_d = ST_CARRIER;
				end
			end
			ST_CARRIER: begin
				cmd.op  = OP_CARRIER;
				chan_d  = 1'b0;
				state_d = ST_LOADX;
			end
			ST_LOADX: begin
				cmd.op  = OP_LOADX;
				pc_d    = '0;
				state_d = ST_RUN;
			end
			ST_RUN: begin
				cmd.op = st.op;
				if ((st.op == OP_DIV1) || (st.op == OP_DIV2)) begin
					state_d = ST_DIV_WAIT;
				end else if (st.last) begin
					state_d = ST_STORE;
				end else begin
					pc_d = pc_q + 1'b1;
				end
			end
			ST_DIV_WAIT: begin
				if (!stat.div_busy) begin
					pc_d    = pc_q + 1'b1;
					state_d = ST_RUN;
				end
			end
			ST_STORE: begin
				cmd.op = OP_STORE;
				if (!chan_q) begin
					chan_d  = 1'b1;
					state_d = ST_LOADX;
				end else begin
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				if (!out_valid_q || m_tready) begin
					cmd.op  = OP_PUSH;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

[src/ring_modulator_multi_model.sv]
// Top level of the stereo ring modulator with selectable carrier and modulation model.
// Each beat on the input carries a stereo Q1.15 pair; the block forms the carrier from its
// phase accumulator, runs the left and then the right channel through the selected model on
// one shared multiplier, and presents one stereo result beat. The diode model takes longest:
// each channel costs its sequence of multiply and arithmetic steps plus, for the digital and
// diode models, a wait in which the bit-serial divider is started, runs its 24 steps and
// hands back its quotient. The finished pair sits in an output register, so the next input
// beat is taken while it waits; a further pair waits until that register is free.
// Configuration writes are taken in every cycle.
`default_nettype none
module ring_modulator_multi_model (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [15:0] left_in, [31:16] right_in
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [15:0] left_out, [31:16] right_out
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	import rmm_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	rmm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rmm_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tdata   (s_tdata),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);
endmodule
`default_nettype wire
